@@ hw/rtl/sle_pkg.sv @@
// ----------------------------------------------------------------------------
// sle_pkg
// Shared codes and types for the sorted list engine: action codes, status
// codes and the command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

    // action codes carried by an input item
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_SEARCH = 3'd2;
    localparam logic [2:0] ACT_POP    = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    // status codes returned with each result item
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_EMPTY    = 2'd3;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the accepted item
        logic compare;  // register the per-entry compares
        logic apply;    // update the list and the result register
    } sle_cmd_t;

endpackage

@@ hw/rtl/sle_ctrl.sv @@
// ----------------------------------------------------------------------------
// sle_ctrl
// Sequencer for the sorted list engine: takes an item, steps it through the
// compare and update phases and owns the result valid flag.
// ----------------------------------------------------------------------------
module sle_ctrl
    import sle_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output sle_cmd_t cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_COMPARE = 2'd1;
    localparam logic [1:0] S_UPDATE  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // command decode
    always_comb begin
        cmd.load    = (state_reg == S_IDLE) && s_valid;
        cmd.compare = (state_reg == S_COMPARE);
        cmd.apply   = (state_reg == S_UPDATE) && out_free;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_COMPARE;
            end
            S_COMPARE: begin
                state_next = S_UPDATE;
            end
            S_UPDATE: begin
                if (out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid: set on update, cleared when the item is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.apply) m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ hw/rtl/sle_datapath.sv @@
// ----------------------------------------------------------------------------
// sle_datapath
// Row of key cells kept in descending order, per-cell compare flags, the key
// count and the result register. Each cell only looks at its neighbors and the item key.
// ----------------------------------------------------------------------------
module sle_datapath
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sle_cmd_t                  cmd,
    input  logic [2:0]                in_action,
    input  logic signed [KEY_W-1:0]   in_key,
    output logic                      res_hit,
    output logic [1:0]                res_status,
    output logic                      res_is_empty,
    output logic signed [KEY_W-1:0]   res_first,
    output logic [COUNT_W-1:0]        res_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [2:0]              act_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] cell_reg  [CAPACITY];
    logic signed [KEY_W-1:0] cell_next [CAPACITY];
    logic signed [KEY_W-1:0] below_src [CAPACITY];
    logic signed [KEY_W-1:0] above_src [CAPACITY];
    logic [CAPACITY-1:0]     eq_reg, eq_next;
    logic [CAPACITY-1:0]     gt_reg, gt_next;
    logic [CAPACITY-1:0]     gt_prev;
    logic [CW-1:0]           count_reg, count_next;
    logic                    found, empty, full;
    logic                    do_insert, do_remove, do_pop;
    logic                    hit_next;
    logic [1:0]              status_next;

    logic                    hit_reg, empty_out_reg;
    logic [1:0]              status_reg;
    logic signed [KEY_W-1:0] first_reg;
    logic [COUNT_W-1:0]      count_out_reg;

    // neighbor taps of each cell
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_taps
            if (g < CAPACITY - 1) begin : g_below
                assign below_src[g] = cell_reg[g+1];
            end else begin : g_last
                assign below_src[g] = cell_reg[g];
            end
            if (g > 0) begin : g_above
                assign above_src[g] = cell_reg[g-1];
                assign gt_prev[g]   = gt_reg[g-1];
            end else begin : g_first
                assign above_src[g] = in_key;
                assign gt_prev[g]   = 1'b1;
            end
        end
    endgenerate

    // per-cell compare against the item key, live entries only
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            eq_next[i] = (CW'(i) < count_reg) && (cell_reg[i] == key_reg);
            gt_next[i] = (CW'(i) < count_reg) && (cell_reg[i] > key_reg);
        end
    end

    assign found = |eq_reg;
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(CAPACITY));

    // action decode
    always_comb begin
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        do_pop      = 1'b0;
        hit_next    = 1'b0;
        status_next = STAT_OK;
        count_next  = count_reg;
        case (act_reg)
            ACT_INSERT: begin
                if (!found) begin
                    if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        do_insert  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ACT_REMOVE: begin
                if (empty) begin
                    status_next = STAT_EMPTY;
                end else if (found) begin
                    do_remove  = 1'b1;
                    hit_next   = 1'b1;
                    count_next = count_reg - 1'b1;
                end else begin
                    status_next = STAT_NOTFOUND;
                end
            end
            ACT_SEARCH: begin
                if (found) hit_next = 1'b1;
                else status_next = STAT_NOTFOUND;
            end
            ACT_POP: begin
                if (empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    do_pop     = 1'b1;
                    hit_next   = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_CLEAR: begin
                count_next = '0;
            end
            default: begin
            end
        endcase
    end

    // cell update: keep, take the key, shift down or shift up
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_next[i] = cell_reg[i];
            if (do_insert && !gt_reg[i]) begin
                cell_next[i] = gt_prev[i] ? key_reg : above_src[i];
            end else if (do_remove && !gt_reg[i]) begin
                cell_next[i] = below_src[i];
            end else if (do_pop) begin
                cell_next[i] = below_src[i];
            end
        end
    end

    // item capture and compare flags
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg <= in_action;
            key_reg <= in_key;
        end
        if (cmd.compare) begin
            eq_reg <= eq_next;
            gt_reg <= gt_next;
        end
    end

    // key cells
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            for (int i = 0; i < CAPACITY; i++) begin
                cell_reg[i] <= cell_next[i];
            end
        end
    end

    // key count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.apply) begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            hit_reg       <= hit_next;
            status_reg    <= status_next;
            empty_out_reg <= (count_next == '0);
            first_reg     <= (count_next == '0) ? '0 : cell_next[0];
            count_out_reg <= COUNT_W'(count_next);
        end
    end

    assign res_hit      = hit_reg;
    assign res_status   = status_reg;
    assign res_is_empty = empty_out_reg;
    assign res_first    = first_reg;
    assign res_count    = count_out_reg;

endmodule

@@ hw/rtl/sorted_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine_core
// Sorted list of up to CAPACITY distinct signed keys, largest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready carries one item: s_action and s_key_value.
//   Actions: insert, remove key, search key, remove first, clear all.
//   Result channel m_valid/m_ready carries one item per input item: hit,
//   status, empty flag, largest key held and the key count after the step.
// Timing:
//   An accepted item is captured, compared against every cell and then
//   applied, and its result shows valid once applied. The controller
//   walks capture, compare and update for one item at a time, so no new
//   item is taken until the last one has been applied.
// Reset:
//   aresetn (synchronous, active low) empties the list and drops any result.
//   Cell contents are not cleared; only entries below the count are used.
// Stall:
//   While a result waits for m_ready the next item is still accepted and
//   compared; its update holds until the pending result is taken.
// ----------------------------------------------------------------------------
module sorted_list_engine_core
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [2:0]              s_action,
    input  logic signed [KEY_W-1:0] s_key_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_hit,
    output logic [1:0]              m_status,
    output logic                    m_is_empty,
    output logic signed [KEY_W-1:0] m_first_value,
    output logic [COUNT_W-1:0]      m_entry_count
);

    sle_cmd_t cmd;

    // sequencer
    sle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // list storage and result
    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_action    (s_action),
        .in_key       (s_key_value),
        .res_hit      (m_hit),
        .res_status   (m_status),
        .res_is_empty (m_is_empty),
        .res_first    (m_first_value),
        .res_count    (m_entry_count)
    );

endmodule

@@ sim/sle_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker
// Watches both channels of the sorted list engine. Keeps its own descending
// key list, works out the result of every accepted input item and compares
// each accepted result item, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sle_checker
    import sle_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [2:0]              s_action,
    input  logic signed [KEY_W-1:0] s_key_value,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic                    m_hit,
    input  logic [1:0]              m_status,
    input  logic                    m_is_empty,
    input  logic signed [KEY_W-1:0] m_first_value,
    input  logic [COUNT_W-1:0]      m_entry_count,
    output int                      fail_count,
    output int                      pending
);

    typedef struct packed {
        logic                    hit;
        logic [1:0]              status;
        logic                    is_empty;
        logic signed [KEY_W-1:0] first_value;
        logic [COUNT_W-1:0]      entry_count;
    } list_result_t;

    // shadow copy of the list, largest key first
    logic signed [KEY_W-1:0] held_keys [CAPACITY];
    int                      held_count;
    list_result_t            expected_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        held_count = 0;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // take out one entry and close the gap
    function automatic void drop_entry(input int pos);
        int idx;
        for (idx = pos; idx + 1 < held_count; idx++) begin
            held_keys[idx] = held_keys[idx + 1];
        end
        held_count--;
    endfunction

    // apply one action to the shadow list and return the result it gives
    function automatic list_result_t apply_action(input logic [2:0] act,
                                                  input logic signed [KEY_W-1:0] key);
        list_result_t res;
        int           pos;
        int           idx;
        res        = '0;
        res.status = STAT_OK;
        pos        = held_count;
        for (idx = 0; idx < held_count; idx++) begin
            if (held_keys[idx] == key) begin
                pos = idx;
                break;
            end
        end
        case (act)
            ACT_INSERT: begin
                // a duplicate leaves the list alone, even when full
                if (pos == held_count) begin
                    if (held_count >= CAPACITY) begin
                        res.status = STAT_FULL;
                    end else begin
                        pos = 0;
                        while (pos < held_count && held_keys[pos] > key) pos++;
                        for (idx = held_count; idx > pos; idx--) begin
                            held_keys[idx] = held_keys[idx - 1];
                        end
                        held_keys[pos] = key;
                        held_count++;
                    end
                end
            end
            ACT_REMOVE: begin
                if (held_count == 0) begin
                    res.status = STAT_EMPTY;
                end else if (pos < held_count) begin
                    drop_entry(pos);
                    res.hit = 1'b1;
                end else begin
                    res.status = STAT_NOTFOUND;
                end
            end
            ACT_SEARCH: begin
                if (pos < held_count) res.hit = 1'b1;
                else res.status = STAT_NOTFOUND;
            end
            ACT_POP: begin
                if (held_count == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    drop_entry(0);
                    res.hit = 1'b1;
                end
            end
            ACT_CLEAR: held_count = 0;
            default: ;
        endcase
        res.is_empty    = (held_count == 0);
        res.first_value = (held_count == 0) ? '0 : held_keys[0];
        res.entry_count = held_count[COUNT_W-1:0];
        return res;
    endfunction

    // results are checked before the new item is predicted in the same cycle
    always @(posedge aclk) begin : watch_channels
        list_result_t want;
        if (!aresetn) begin
            held_count = 0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result item with no input item outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (m_hit !== want.hit)
                        report_mismatch($sformatf("hit: got %0d, expected %0d",
                                                  m_hit, want.hit));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status: got %0d, expected %0d",
                                                  m_status, want.status));
                    if (m_is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty: got %0d, expected %0d",
                                                  m_is_empty, want.is_empty));
                    if (m_first_value !== want.first_value)
                        report_mismatch($sformatf("first_value: got %0d, expected %0d",
                                                  m_first_value, want.first_value));
                    if (m_entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count: got %0d, expected %0d",
                                                  m_entry_count, want.entry_count));
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(apply_action(s_action, s_key_value));
            end
        end
        pending = expected_q.size();
    end

endmodule

@@ sim/tb_sorted_list_engine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_list_engine_core
// Drives the sorted list engine with a short directed run over the corner
// cases, then random episodes that fill, drain or mix the list, with random
// gaps on both channels, one long receiver hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_sorted_list_engine_core;
    import sle_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 930;
    localparam int POOL_SIZE    = 24;
    localparam int HOLD_CYCLES  = 80;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_AT      = 400;
    localparam int PAUSE_AT     = 650;
    localparam int STEADY_FROM  = 100;
    localparam int STEADY_TO    = 260;

    localparam logic [2:0]              ACT_UNUSED_LO = 3'd5;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} sweep_mode_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [2:0]              s_action = ACT_INSERT;
    logic signed [KEY_W-1:0] s_key_value = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_hit;
    logic [1:0]              m_status;
    logic                    m_is_empty;
    logic signed [KEY_W-1:0] m_first_value;
    logic [COUNT_W-1:0]      m_entry_count;
    int                      fail_count;
    int                      pending;

    bit                      steady = 1'b0;
    bit                      hold_req = 1'b0;
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    sorted_list_engine_core #(.CAPACITY(CAPACITY)) DUT (.*);

    sle_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // offer one item, with random gaps before it, and wait for acceptance
    task automatic send_item(input logic [2:0] act, input logic signed [KEY_W-1:0] key);
        while (!steady && $urandom_range(99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_action    <= act;
        s_key_value <= key;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // new episode keys: half near zero so they collide often
    task automatic refill_pool();
        int j;
        for (j = 0; j < POOL_SIZE; j++) begin
            if ($urandom_range(1)) key_pool[j] = $signed($urandom_range(40)) - 20;
            else key_pool[j] = $urandom;
        end
    endtask

    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 6) begin
            case ($urandom_range(3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return '0;
                default: return -1;
            endcase
        end
        if (r < 20) return $urandom;
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [2:0] pick_action(input sweep_mode_t mode);
        int r;
        r = $urandom_range(99);
        case (mode)
            MODE_FILL: begin
                if (r < 65) return ACT_INSERT;
                if (r < 78) return ACT_SEARCH;
                if (r < 88) return ACT_REMOVE;
                if (r < 95) return ACT_POP;
                if (r < 97) return ACT_CLEAR;
            end
            MODE_DRAIN: begin
                if (r < 20) return ACT_INSERT;
                if (r < 50) return ACT_REMOVE;
                if (r < 75) return ACT_POP;
                if (r < 90) return ACT_SEARCH;
                if (r < 93) return ACT_CLEAR;
            end
            default: begin
                if (r < 35) return ACT_INSERT;
                if (r < 55) return ACT_REMOVE;
                if (r < 80) return ACT_SEARCH;
                if (r < 90) return ACT_POP;
                if (r < 94) return ACT_CLEAR;
            end
        endcase
        return ACT_UNUSED_LO + 3'($urandom_range(2));
    endfunction

    // receiver: random stalls, a steady stretch, and one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 23);
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int          n;
        int          episode_left;
        sweep_mode_t mode;
        episode_left = 0;
        mode         = MODE_FILL;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty-list cases
        send_item(ACT_POP, '0);
        send_item(ACT_REMOVE, 5);
        send_item(ACT_SEARCH, 5);
        // extremes and ordering
        send_item(ACT_INSERT, '0);
        send_item(ACT_INSERT, KEY_MAX);
        send_item(ACT_INSERT, KEY_MIN);
        send_item(ACT_INSERT, -1);
        send_item(ACT_INSERT, 1);
        send_item(ACT_INSERT, '0);
        // search hit and miss, remove hit and miss, remove first
        send_item(ACT_SEARCH, -1);
        send_item(ACT_SEARCH, 5);
        send_item(ACT_REMOVE, 1);
        send_item(ACT_REMOVE, 7);
        send_item(ACT_POP, '0);
        // unused action codes leave the list alone
        send_item(ACT_UNUSED_LO, $urandom);
        send_item(ACT_UNUSED_LO + 3'd1, $urandom);
        send_item(ACT_UNUSED_LO + 3'd2, $urandom);
        send_item(ACT_CLEAR, $urandom);
        send_item(ACT_POP, '0);

        // random episodes
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (episode_left == 0) begin
                episode_left = $urandom_range(25, 55);
                mode = sweep_mode_t'($urandom_range(2));
                refill_pool();
            end
            episode_left--;
            steady = (n >= STEADY_FROM && n < STEADY_TO);
            if (n == HOLD_AT) hold_req = 1'b1;
            if (n == PAUSE_AT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
                while (pending != 0) @(negedge aclk);
                @(posedge aclk);
            end
            send_item(pick_action(mode), pick_key());
        end
        s_valid <= 1'b0;

        // drain and let the pipeline settle
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
